/* rtl/tgr_pkg.sv */
// Shared types and constants of the text glyph renderer.
package tgr_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 8;
    localparam int FONT_CHARS   = 256;

    localparam int STORE_DEPTH = FONT_CHARS * GLYPH_WIDTH;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int ROW_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 16;
    localparam int S_DATA_W    = 48;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 48;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // input action codes
    localparam logic [S_USER_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [S_USER_W-1:0] ACT_CURSOR = 2'd1;
    localparam logic [S_USER_W-1:0] ACT_DRAW   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH      = 2'd2;

    // result kinds
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_DRAW   = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [ADDR_W-1:0]    addr;
        logic [BYTE_W-1:0]    data;   // font byte or character code
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [COORD_W-1:0] width;
    } cfg_t;

endpackage

/* rtl/tgr_front.sv */
// Front end: accepts input items, drops no-op items and decodes the rest into commands.
module tgr_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tgr_pkg::S_USER_W-1:0]   s_tuser,
    input  logic [tgr_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           q_full,
    output logic                           push,
    output tgr_pkg::cmd_t                  push_cmd
);
    import tgr_pkg::*;

    logic keep;

    assign s_tready = !q_full;

    always_comb
    begin
        push_cmd.addr = s_tdata[10:0];
        push_cmd.x    = s_tdata[26:19];
        push_cmd.y    = s_tdata[34:27];
        push_cmd.op   = CMD_LOAD;
        push_cmd.data = s_tdata[18:11];
        keep          = 1'b0;
        unique case (s_tuser)
            ACT_LOAD:
            begin
                push_cmd.op = CMD_LOAD;
                // drop loads beyond the font store
                keep = ({1'b0, s_tdata[10:0]} < (ADDR_W + 1)'(STORE_DEPTH));
            end
            ACT_CURSOR:
            begin
                push_cmd.op = CMD_CURSOR;
                keep        = 1'b1;
            end
            ACT_DRAW:
            begin
                push_cmd.op   = CMD_DRAW;
                push_cmd.data = s_tdata[42:35];
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

endmodule

/* rtl/tgr_queue.sv */
// Short command queue between the front end and the draw engine.
module tgr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tgr_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tgr_pkg::cmd_t  head_cmd
);
    import tgr_pkg::*;

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/tgr_back.sv */
// Draw engine: font store, cursor, glyph fetch and pixel sequencer with output register.
module tgr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tgr_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  tgr_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tgr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import tgr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_WIN   = 4'b0100,
        ST_PIX   = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [COORD_W-1:0]     cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0]     cursor_y_reg, cursor_y_next;
    logic [STORE_AW-1:0]    base_reg, base_next;
    logic                   blank_reg, blank_next;
    logic [COL_W-1:0]       fetch_col_reg, fetch_col_next;
    logic                   cap_valid_reg, cap_valid_next;
    logic [COL_W-1:0]       cap_col_reg, cap_col_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg;
    logic                   out_last_reg;
    logic [M_DATA_W-1:0]    out_data_reg;

    logic [BYTE_W-1:0]       font_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]       rd_data_reg;
    logic [STORE_AW-1:0]     rd_addr;
    logic                    mem_we;
    logic [GLYPH_HEIGHT-1:0] glyph_reg [GLYPH_WIDTH];

    logic                    out_free;
    logic                    out_load;
    logic                    pix_last;
    logic [COLOR_W-1:0]      pix_color;
    logic [COORD_W-1:0]      step_x;
    logic [COORD_W:0]        wrap_sum;
    logic [M_DATA_W-1:0]     load_data;
    logic                    load_kind;
    logic [2*ADDR_W-1:0]     base_full;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign mem_we   = q_pop && (q_cmd.op == CMD_LOAD);
    assign rd_addr  = base_reg + STORE_AW'(fetch_col_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == ST_WIN) || (state_reg == ST_PIX));
    assign pix_last = (row_reg == ROW_W'(GLYPH_HEIGHT - 1)) && (col_reg == COL_W'(GLYPH_WIDTH - 1));
    assign pix_color = glyph_reg[col_reg][row_reg] ? cfg.fg : cfg.bg;
    assign base_full = (2 * ADDR_W)'(q_cmd.data) * (2 * ADDR_W)'(GLYPH_WIDTH);

    // cursor step after a draw, with wrap to the next text line
    assign step_x   = cursor_x_reg + COORD_W'(GLYPH_WIDTH + 1);
    assign wrap_sum = {1'b0, step_x} + (COORD_W + 1)'(GLYPH_WIDTH);

    always_comb
    begin
        if (state_reg == ST_WIN)
        begin
            load_kind = KIND_WINDOW;
            load_data = {COLOR_W'(0),
                         cursor_y_reg + COORD_W'(GLYPH_HEIGHT - 1),
                         cursor_x_reg + COORD_W'(GLYPH_WIDTH - 1),
                         cursor_y_reg,
                         cursor_x_reg};
        end
        else
        begin
            load_kind = KIND_PIXEL;
            load_data = {pix_color, (4 * COORD_W)'(0)};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        base_next      = base_reg;
        blank_next     = blank_reg;
        fetch_col_next = fetch_col_reg;
        cap_valid_next = 1'b0;
        cap_col_next   = fetch_col_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_cmd.op)
                        CMD_CURSOR:
                        begin
                            cursor_x_next = q_cmd.x;
                            cursor_y_next = q_cmd.y;
                        end
                        CMD_DRAW:
                        begin
                            base_next      = STORE_AW'(base_full);
                            blank_next     = ({1'b0, q_cmd.data} >= (BYTE_W + 1)'(FONT_CHARS));
                            fetch_col_next = '0;
                            state_next     = ST_FETCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // issue one column read a cycle; the registered read data is then captured into the glyph columns
                cap_valid_next = 1'b1;
                if (fetch_col_reg == COL_W'(GLYPH_WIDTH - 1))
                begin
                    state_next = ST_WIN;
                end
                else
                begin
                    fetch_col_next = fetch_col_reg + 1'b1;
                end
            end
            ST_WIN:
            begin
                if (out_load)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_PIX;
                    if (wrap_sum >= {1'b0, cfg.width})
                    begin
                        cursor_x_next = '0;
                        cursor_y_next = cursor_y_reg + COORD_W'(GLYPH_HEIGHT + 2);
                    end
                    else
                    begin
                        cursor_x_next = step_x;
                    end
                end
            end
            ST_PIX:
            begin
                if (out_load)
                begin
                    if (pix_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (col_reg == COL_W'(GLYPH_WIDTH - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            fetch_col_reg <= '0;
            cap_valid_reg <= 1'b0;
            cap_col_reg   <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            fetch_col_reg <= fetch_col_next;
            cap_valid_reg <= cap_valid_next;
            cap_col_reg   <= cap_col_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        blank_reg <= blank_next;
        if (out_load)
        begin
            out_kind_reg <= load_kind;
            out_last_reg <= (state_reg == ST_PIX) && pix_last;
            out_data_reg <= load_data;
        end
        if (cap_valid_reg)
        begin
            glyph_reg[cap_col_reg] <= blank_reg ? '0 : rd_data_reg[GLYPH_HEIGHT-1:0];
        end
    end

    // font store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[q_cmd.addr[STORE_AW-1:0]] <= q_cmd.data;
        end
        rd_data_reg <= font_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while a draw is in progress");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (state_reg == ST_PIX) && pix_last) |=> (state_reg == ST_IDLE))
        else $error("draw did not end after its final pixel");

    a_window_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_WINDOW)) |-> !out_last_reg)
        else $error("window result marked last");

    a_capture_window: assert property (@(posedge clk) disable iff (!rst_n)
        cap_valid_reg |-> ((state_reg == ST_FETCH) || (state_reg == ST_WIN)))
        else $error("glyph capture outside the fetch phase");
`endif

endmodule

/* rtl/text_glyph_renderer_top.sv */
// Top level of the text glyph renderer: configuration registers and block wiring.
// Usage:
//   Input items arrive on s_tvalid/s_tready with the action in s_tuser. A load
//   writes one glyph column into the font store, a set-cursor moves the text
//   cursor, a draw renders one character at the cursor. Action 3 and loads
//   beyond the font store are dropped at the front end.
//   A draw emits one window item (m_tuser = 0), then 40 pixel items (m_tuser = 1)
//   row by row, left to right; m_tlast marks the final pixel. Colors and screen
//   width are written on cfg_valid/cfg_ready, always ready; the user must write
//   them only while idle; the block itself does not enforce this.
// Draw sequence:
//   A draw item is queued, taken by the idle engine, its five glyph columns are
//   read through the single font store read port, then the window item and the
//   pixel items follow, one item a cycle while m_tready is high. Loads and cursor
//   moves finish when the engine takes them. A four-entry command queue keeps
//   accepting while a draw runs; s_tready drops only when it is full.
// Reset: cursor (0, 0), foreground 0xFFFF, background 0, width 128, queue and
//   output empty. The font store is not cleared and must be loaded before use.
// Stall: a low m_tready holds the output item and the engine; the queue then
//   fills and backpressures the input.
module text_glyph_renderer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tgr_pkg::S_USER_W-1:0]      s_tuser,   // action
    // s_tdata from bit 0: font_address[10:0], font_byte[18:11], start_x[26:19],
    // start_y[34:27], char_code[42:35], zero fill [47:43]
    input  logic [tgr_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: win_x0[7:0], win_y0[15:8], win_x1[23:16],
    // win_y1[31:24], pixel_color[47:32]
    output logic [tgr_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tuser,   // kind
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tgr_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;

    // Configuration is always accepted; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FOREGROUND: cfg_next.fg    = cfg_data;
                REG_BACKGROUND: cfg_next.bg    = cfg_data;
                REG_WIDTH:      cfg_next.width = cfg_data[COORD_W-1:0];
                default:        cfg_next       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg    <= 16'hFFFF;
            cfg_reg.bg    <= 16'h0000;
            cfg_reg.width <= 8'd128;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept and classify input items.
    tgr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue: decouple acceptance from drawing.
    tgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // Back end: font store, cursor and pixel generation.
    tgr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* dv/text_glyph_renderer_top_tb.sv */
// Self-checking testbench of the text glyph renderer: predicted window and pixel items.
`timescale 1ns / 1ps

// Predicts the window and pixel items of every accepted command, then checks the
// items that leave the block against them in order.
class glyph_render_checker;

    typedef struct {
        logic        kind;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [7:0]  x1;
        logic [7:0]  y1;
        logic [15:0] color;
        logic        last;
    } render_item_t;

    logic [7:0]   font_store [0:tgr_pkg::STORE_DEPTH-1];
    logic [7:0]   cursor_col;
    logic [7:0]   cursor_row;
    logic [15:0]  fg_color;
    logic [15:0]  bg_color;
    logic [7:0]   screen_width;
    render_item_t owed_items [$];
    int unsigned  mismatches;

    function new();
        cursor_col   = 8'd0;
        cursor_row   = 8'd0;
        fg_color     = 16'hFFFF;
        bg_color     = 16'h0000;
        screen_width = 8'd128;
        mismatches   = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [15:0] value);
        case (index)
            tgr_pkg::REG_FOREGROUND: fg_color = value;
            tgr_pkg::REG_BACKGROUND: bg_color = value;
            tgr_pkg::REG_WIDTH:      screen_width = value[7:0];
            default: ;
        endcase
    endfunction

    function void take_command(logic [1:0] act, logic [10:0] addr, logic [7:0] fbyte,
                               logic [7:0] sx, logic [7:0] sy, logic [7:0] code);
        render_item_t it;
        logic [7:0]   column;
        int           next_col;
        case (act)
            tgr_pkg::ACT_LOAD:
            begin
                if (addr < tgr_pkg::STORE_DEPTH)
                    font_store[addr] = fbyte;
            end
            tgr_pkg::ACT_CURSOR:
            begin
                cursor_col = sx;
                cursor_row = sy;
            end
            tgr_pkg::ACT_DRAW:
            begin
                it.kind  = tgr_pkg::KIND_WINDOW;
                it.x0    = cursor_col;
                it.y0    = cursor_row;
                it.x1    = 8'(cursor_col + tgr_pkg::GLYPH_WIDTH - 1);
                it.y1    = 8'(cursor_row + tgr_pkg::GLYPH_HEIGHT - 1);
                it.color = 16'h0000;
                it.last  = 1'b0;
                owed_items.push_back(it);
                for (int row = 0; row < tgr_pkg::GLYPH_HEIGHT; row++)
                begin
                    for (int col = 0; col < tgr_pkg::GLYPH_WIDTH; col++)
                    begin
                        column = 8'h00;
                        if (code < tgr_pkg::FONT_CHARS)
                            column = font_store[code * tgr_pkg::GLYPH_WIDTH + col];
                        it.kind  = tgr_pkg::KIND_PIXEL;
                        it.x0    = 8'd0;
                        it.y0    = 8'd0;
                        it.x1    = 8'd0;
                        it.y1    = 8'd0;
                        it.color = column[row] ? fg_color : bg_color;
                        it.last  = (row == tgr_pkg::GLYPH_HEIGHT - 1) &&
                                   (col == tgr_pkg::GLYPH_WIDTH - 1);
                        owed_items.push_back(it);
                    end
                end
                // advance the cursor, wrap to a new line near the right edge
                next_col = (cursor_col + tgr_pkg::GLYPH_WIDTH + 1) % 256;
                if (next_col + tgr_pkg::GLYPH_WIDTH >= int'(screen_width))
                begin
                    next_col   = 0;
                    cursor_row = 8'(cursor_row + tgr_pkg::GLYPH_HEIGHT + 2);
                end
                cursor_col = 8'(next_col);
            end
            default: ;
        endcase
    endfunction

    function void match(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    function void check_item(logic kind, logic [47:0] data, logic last);
        render_item_t want;
        if (owed_items.size() == 0)
        begin
            $error("item with no expectation: kind %0h, data %0h", kind, data);
            mismatches++;
            return;
        end
        want = owed_items.pop_front();
        match("kind", 16'(want.kind), 16'(kind));
        match("win_x0", 16'(want.x0), 16'(data[7:0]));
        match("win_y0", 16'(want.y0), 16'(data[15:8]));
        match("win_x1", 16'(want.x1), 16'(data[23:16]));
        match("win_y1", 16'(want.y1), 16'(data[31:24]));
        match("pixel_color", want.color, data[47:32]);
        match("last", 16'(want.last), 16'(last));
    endfunction

endclass

module text_glyph_renderer_top_tb;

    import tgr_pkg::*;

    // the action code that the block drops
    localparam logic [S_USER_W-1:0] ACT_UNUSED = 2'd3;

    // a draw keeps the engine busy; leave room for a full command queue
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 40;
    localparam int MAX_ADDR      = 2047;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_USER_W-1:0]    s_tuser;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // calm turns off idling on both sides for one whole phase
    logic                   calm;
    int unsigned            cycle_count;
    bit                     col_loaded [0:STORE_DEPTH-1];
    glyph_render_checker    board;

    text_glyph_renderer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout guard: a hung handshake or a missing item ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: check every accepted item, then pick the next ready level.
    // Sampling at the edge sees the values from before it, so no race with the block.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_item(m_tuser, m_tdata, m_tlast);
        m_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    // Offer one command item, idling at random first, and hold it until taken.
    // Valid stays high at the end so that a following item needs no second assignment.
    task automatic send_item(input logic [S_USER_W-1:0] act, input logic [10:0] addr,
                             input logic [7:0] fbyte, input logic [7:0] sx,
                             input logic [7:0] sy, input logic [7:0] code);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b00000, code, sy, sx, fbyte, addr};
        do
            @(posedge clk);
        while (!s_tready);
        board.take_command(act, addr, fbyte, sx, sy, code);
        if (act == ACT_LOAD && addr < STORE_DEPTH)
            col_loaded[addr] = 1'b1;
    endtask

    // Unused fields of every item carry random bits.
    task automatic load_font(input int unsigned addr, input logic [7:0] fbyte);
        send_item(ACT_LOAD, 11'(addr), fbyte, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic set_cursor(input logic [7:0] x, input logic [7:0] y);
        send_item(ACT_CURSOR, 11'($urandom), 8'($urandom), x, y, 8'($urandom));
    endtask

    task automatic draw_char(input logic [7:0] code);
        send_item(ACT_DRAW, 11'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), code);
    endtask

    // Drop valid, wait until every owed item has left, then let queued loads settle.
    // The queue is read at the falling edge, clear of the checker's updates.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed_items.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(index, value);
    endtask

    task automatic write_settings(input logic [15:0] fg, input logic [15:0] bg,
                                  input logic [7:0] width);
        write_register(REG_FOREGROUND, fg);
        write_register(REG_BACKGROUND, bg);
        write_register(REG_WIDTH, {8'h00, width});
        cfg_valid <= 1'b0;
    endtask

    // Pick a character whose five columns are all loaded; never draw unwritten glyphs.
    function automatic logic [7:0] pick_code();
        logic [7:0] code;
        bit         ready;
        for (int tries = 0; tries < 8; tries++)
        begin
            code  = 8'($urandom);
            ready = 1'b1;
            for (int c = 0; c < GLYPH_WIDTH; c++)
                ready &= col_loaded[code * GLYPH_WIDTH + c];
            if (ready)
                return code;
        end
        return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endfunction

    // One random phase: whole glyph loads, draws, cursor moves, stray loads and
    // noise. Dropped items (loads past the store, the unused action) are not counted.
    task automatic run_random_phase(input int unsigned target);
        int unsigned counted;
        int unsigned pick;
        logic [7:0]  code;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                code = 8'($urandom);
                for (int c = 0; c < GLYPH_WIDTH; c++)
                    load_font(code * GLYPH_WIDTH + c, 8'($urandom));
                counted += GLYPH_WIDTH;
            end
            else if (pick < 52)
            begin
                draw_char(pick_code());
                counted++;
            end
            else if (pick < 66)
            begin
                set_cursor(8'($urandom), 8'($urandom));
                counted++;
            end
            else if (pick < 82)
            begin
                load_font($urandom_range(0, STORE_DEPTH - 1), 8'($urandom));
                counted++;
            end
            else if (pick < 92)
                load_font($urandom_range(STORE_DEPTH, MAX_ADDR), 8'($urandom));
            else
                send_item(ACT_UNUSED, 11'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        board       = new();
        cycle_count = 0;
        calm        <= 1'b0;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= ACT_LOAD;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_FOREGROUND;
        cfg_data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extreme colors, glyphs 0 and 255 with edge bit patterns.
        write_settings(16'hFFFF, 16'h0000, 8'd128);
        load_font(0, 8'h00);
        load_font(1, 8'hFF);
        load_font(2, 8'hA5);
        load_font(3, 8'h5A);
        load_font(4, 8'h81);
        load_font(255 * GLYPH_WIDTH + 0, 8'hFF);
        load_font(255 * GLYPH_WIDTH + 1, 8'h01);
        load_font(255 * GLYPH_WIDTH + 2, 8'h80);
        load_font(255 * GLYPH_WIDTH + 3, 8'h3C);
        load_font(255 * GLYPH_WIDTH + 4, 8'hC3);
        // loads past the font store and the unused action must leave no trace
        load_font(MAX_ADDR, 8'hFF);
        load_font(STORE_DEPTH, 8'h00);
        send_item(ACT_UNUSED, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // window corners wrap past 255 on both axes
        set_cursor(8'd253, 8'd252);
        draw_char(8'd255);
        draw_char(8'd0);
        // a draw near the right edge wraps to the next text line
        set_cursor(8'd120, 8'd0);
        draw_char(8'd0);
        draw_char(8'd255);
        draw_char(8'd255);

        // Random phases, each with its own settings written while idle:
        // widest screen, narrowest legal, a calm phase, zero and tiny widths.
        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            case (phase)
                0: write_settings(16'h0000, 16'hFFFF, 8'd255);
                1: write_settings(16'($urandom), 16'($urandom), 8'd8);
                2: write_settings(16'($urandom), 16'($urandom), 8'($urandom_range(9, 254)));
                3: write_settings(16'($urandom), 16'($urandom), 8'd0);
                default: write_settings(16'($urandom), 16'($urandom), 8'($urandom_range(1, 7)));
            endcase
            calm <= (phase == 2);
            run_random_phase(PHASE_ITEMS);
            calm <= 1'b0;
        end

        drain();
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* text_glyph_renderer_top.f */
rtl/tgr_pkg.sv
rtl/tgr_front.sv
rtl/tgr_queue.sv
rtl/tgr_back.sv
rtl/text_glyph_renderer_top.sv
dv/text_glyph_renderer_top_tb.sv
